// ===== rtl/ptssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptssm_pkg
// Shared types and constants for the per-track sleep state machine: track
// modes, back-end sequencer states, configuration indexes and reset values.
// ----------------------------------------------------------------------------
package ptssm_pkg;

    // Track modes, as stored in the table and returned on track_state
    typedef enum logic [1:0] {
        MODE_NORMAL     = 2'd0,
        MODE_SUSPECTED  = 2'd1,
        MODE_SLEEPING   = 2'd2,
        MODE_RECOVERING = 2'd3
    } mode_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } back_state_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_HOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_HOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ABSENT_RESET = 2'd2;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] SLEEP_HOLD_RST = 32'd10000;
    localparam logic [CFG_DATA_W-1:0] RECOVERY_HOLD_RST = 32'd3000;
    localparam logic [CFG_DATA_W-1:0] ABSENT_RESET_RST = 32'd2000;

    // Evidence codes
    localparam logic [1:0] SIG_ABSENT = 2'd0;

    // Field widths fixed by the interface
    localparam int ID_W = 6;
    localparam int STAMP_W = 40;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [CFG_DATA_W-1:0] sleep_hold;
        logic [CFG_DATA_W-1:0] recovery_hold;
        logic [CFG_DATA_W-1:0] absent_reset;
    } cfg_t;

    // Classified evidence of one item, passed from front to back
    typedef struct packed {
        logic                  absent;
        logic                  sleep;
        logic                  cand;
        logic [CFG_DATA_W-1:0] hold;
    } cls_t;

endpackage

// ===== rtl/per_track_sleep_state_machine.sv =====
// ----------------------------------------------------------------------------
// In the back end each observation is first read from the single-port state
// table (BK_IDLE) and then updated and written back (BK_EXEC) while the result
// is loaded into the output register; BK_EXEC waits while the last result is
// not yet taken, and one item is finished before the next is read. A two-entry
// queue lets the input side keep taking items while a result waits on the
// output. After reset the table is cleared one entry a cycle, during which
// in_ready is low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// per_track_sleep_state_machine
// Top level: configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
module per_track_sleep_state_machine
    import ptssm_pkg::*;
#(
    parameter int NUM_TRACKS = 64,
    parameter int TIME_BITS  = 40
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ID_W-1:0]       track_id,
    input  logic [STAMP_W-1:0]    timestamp_ms,
    input  logic [1:0]            sleep_signal,
    input  logic [1:0]            suspect_signal,
    input  logic [CFG_DATA_W-1:0] hold_override_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            track_state,
    output logic                  state_changed,
    output logic                  sleep_entered,
    output logic [STAMP_W-1:0]    time_in_state_ms
);

    localparam int IDX_W = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
    localparam int CLS_W = $bits(cls_t);
    localparam int Q_W   = IDX_W + TIME_BITS + CLS_W;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic                 clearing;
    logic                 f_push;
    logic [IDX_W-1:0]     f_idx;
    logic [TIME_BITS-1:0] f_now;
    cls_t                 f_cls;
    logic                 q_ready;
    logic                 q_valid;
    logic                 q_pop;
    logic [Q_W-1:0]       q_data;

    // Configuration register writes; unmapped indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLEEP_HOLD:    cfg_next.sleep_hold    = cfg_data;
                CFG_RECOVERY_HOLD: cfg_next.recovery_hold = cfg_data;
                CFG_ABSENT_RESET:  cfg_next.absent_reset  = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sleep_hold    <= SLEEP_HOLD_RST;
            cfg_reg.recovery_hold <= RECOVERY_HOLD_RST;
            cfg_reg.absent_reset  <= ABSENT_RESET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept and classify
    ptssm_front #(
        .NUM_TRACKS (NUM_TRACKS),
        .TIME_BITS  (TIME_BITS),
        .IDX_W      (IDX_W)
    ) u_front (
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .track_id         (track_id),
        .timestamp_ms     (timestamp_ms),
        .sleep_signal     (sleep_signal),
        .suspect_signal   (suspect_signal),
        .hold_override_ms (hold_override_ms),
        .sleep_hold       (cfg_reg.sleep_hold),
        .clearing         (clearing),
        .q_ready          (q_ready),
        .q_push           (f_push),
        .q_idx            (f_idx),
        .q_now            (f_now),
        .q_cls            (f_cls)
    );

    // Decouple front and back
    ptssm_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .push_data  ({f_idx, f_now, f_cls}),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    // Carry out the update
    ptssm_back #(
        .NUM_TRACKS (NUM_TRACKS),
        .TIME_BITS  (TIME_BITS),
        .IDX_W      (IDX_W)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_idx            (q_data[Q_W-1 -: IDX_W]),
        .q_now            (q_data[CLS_W +: TIME_BITS]),
        .q_cls            (cls_t'(q_data[CLS_W-1:0])),
        .clearing         (clearing),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .track_state      (track_state),
        .state_changed    (state_changed),
        .sleep_entered    (sleep_entered),
        .time_in_state_ms (time_in_state_ms)
    );

endmodule

// ===== rtl/ptssm_front.sv =====
// ----------------------------------------------------------------------------
// ptssm_front
// Input side: takes items, folds the track id onto the table, decodes the
// evidence codes and resolves the sleep hold time for the item.
// ----------------------------------------------------------------------------
module ptssm_front
    import ptssm_pkg::*;
#(
    parameter int NUM_TRACKS = 64,
    parameter int TIME_BITS  = 40,
    parameter int IDX_W      = 6
) (
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ID_W-1:0]       track_id,
    input  logic [STAMP_W-1:0]    timestamp_ms,
    input  logic [1:0]            sleep_signal,
    input  logic [1:0]            suspect_signal,
    input  logic [CFG_DATA_W-1:0] hold_override_ms,
    input  logic [CFG_DATA_W-1:0] sleep_hold,
    input  logic                  clearing,
    input  logic                  q_ready,
    output logic                  q_push,
    output logic [IDX_W-1:0]      q_idx,
    output logic [TIME_BITS-1:0]  q_now,
    output cls_t                  q_cls
);

    localparam int REM_W = 19;

    logic [REM_W-1:0] rem;
    logic             sleep;

    // Accept while the queue has room and the table is not being cleared
    assign in_ready = q_ready && !clearing;
    assign q_push   = in_valid && in_ready;

    // Fold the id onto the table by restoring remainder, one bit a step
    always_comb
    begin
        rem = REM_W'(track_id);
        for (int s = ID_W - 1; s >= 0; s--)
        begin
            if (rem >= (REM_W'(NUM_TRACKS) << s))
            begin
                rem = rem - (REM_W'(NUM_TRACKS) << s);
            end
        end
    end

    assign q_idx = rem[IDX_W-1:0];
    assign q_now = TIME_BITS'(timestamp_ms);

    // Decode evidence: codes two and three both read as true
    assign sleep = sleep_signal[1];

    always_comb
    begin
        q_cls.absent = (sleep_signal == SIG_ABSENT);
        q_cls.sleep  = sleep;
        q_cls.cand   = (suspect_signal == SIG_ABSENT) ? sleep : suspect_signal[1];
        q_cls.hold   = (hold_override_ms != '0) ? hold_override_ms : sleep_hold;
    end

endmodule

// ===== rtl/ptssm_queue.sv =====
// ----------------------------------------------------------------------------
// ptssm_queue
// Two-entry queue between front and back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module ptssm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/ptssm_back.sv =====
// ----------------------------------------------------------------------------
// ptssm_back
// Execution side: reads the track's entry from the table, runs the mode
// machine and its three timers, writes the entry back and loads the result
// register. Clears the table once after reset.
// ----------------------------------------------------------------------------
module ptssm_back
    import ptssm_pkg::*;
#(
    parameter int NUM_TRACKS = 64,
    parameter int TIME_BITS  = 40,
    parameter int IDX_W      = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  logic [IDX_W-1:0]     q_idx,
    input  logic [TIME_BITS-1:0] q_now,
    input  cls_t                 q_cls,
    output logic                 clearing,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           track_state,
    output logic                 state_changed,
    output logic                 sleep_entered,
    output logic [STAMP_W-1:0]   time_in_state_ms
);

    localparam int T     = TIME_BITS;
    localparam int ENT_W = 4 * T + 6;

    // Entry layout, low to high: absent_since, calm_since, low_since,
    // mode_since, absent valid, calm valid, low valid, mode, known
    localparam int AV_B = 4 * T;
    localparam int CV_B = 4 * T + 1;
    localparam int LV_B = 4 * T + 2;
    localparam int MD_B = 4 * T + 3;
    localparam int KN_B = 4 * T + 5;

    logic [ENT_W-1:0] table_mem [NUM_TRACKS];
    logic [ENT_W-1:0] rd_reg;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] clr_cnt_next;

    logic [IDX_W-1:0] w_idx_reg;
    logic [T-1:0]     w_now_reg;
    cls_t             w_cls_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [1:0]       track_state_reg;
    logic             state_changed_reg;
    logic             sleep_entered_reg;
    logic [STAMP_W-1:0] time_in_state_reg;

    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic             commit;

    // Working copy of the entry
    mode_t        md;
    logic [T-1:0] ms;
    logic [T-1:0] ls;
    logic [T-1:0] cs;
    logic [T-1:0] as_t;
    logic         lv;
    logic         cv;
    logic         av;
    logic         known;
    logic         changed;
    logic         entered;
    logic [T-1:0] tis;
    logic [ENT_W-1:0] new_entry;

    // Elapsed time since a mark, clamped at zero, compared with a limit
    function automatic logic reached(input logic [T-1:0] now_v,
                                     input logic [T-1:0] since_v,
                                     input logic [CFG_DATA_W-1:0] lim);
        logic [T-1:0] el;
        begin
            el = (now_v >= since_v) ? (now_v - since_v) : '0;
            return el >= T'(lim);
        end
    endfunction

    assign clearing = (state_reg == BK_CLEAR);

    // Sequencer: clear pass, then read the entry and execute the update
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        q_pop        = 1'b0;
        rd_en        = 1'b0;
        commit       = 1'b0;
        unique case (state_reg)
            BK_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(NUM_TRACKS - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    rd_en      = 1'b1;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit     = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Capture the item being worked on
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            w_idx_reg <= q_idx;
            w_now_reg <= q_now;
            w_cls_reg <= q_cls;
        end
    end

    // Run the mode machine on the entry read back from the table
    always_comb
    begin
        known = rd_reg[KN_B];
        md    = known ? mode_t'(rd_reg[MD_B +: 2]) : MODE_NORMAL;
        ms    = known ? rd_reg[3*T +: T] : w_now_reg;
        ls    = rd_reg[2*T +: T];
        cs    = rd_reg[T +: T];
        as_t  = rd_reg[0 +: T];
        lv    = known && rd_reg[LV_B];
        cv    = known && rd_reg[CV_B];
        av    = known && rd_reg[AV_B];
        changed = 1'b0;
        entered = 1'b0;

        if (w_cls_reg.absent)
        begin
            if (!av)
            begin
                av   = 1'b1;
                as_t = w_now_reg;
            end
            else if (reached(w_now_reg, as_t, cfg.absent_reset))
            begin
                changed = (md != MODE_NORMAL);
                if (changed)
                begin
                    md = MODE_NORMAL;
                    ms = w_now_reg;
                end
                lv = 1'b0;
                cv = 1'b0;
                av = 1'b0;
            end
        end
        else
        begin
            av = 1'b0;
            unique case (md)
                MODE_NORMAL:
                begin
                    if (w_cls_reg.cand)
                    begin
                        lv      = w_cls_reg.sleep;
                        ls      = w_now_reg;
                        md      = MODE_SUSPECTED;
                        ms      = w_now_reg;
                        changed = 1'b1;
                    end
                end
                MODE_SUSPECTED:
                begin
                    if (!w_cls_reg.cand)
                    begin
                        md      = MODE_NORMAL;
                        ms      = w_now_reg;
                        changed = 1'b1;
                        lv      = 1'b0;
                        cv      = 1'b0;
                    end
                    else if (w_cls_reg.sleep)
                    begin
                        if (!lv)
                        begin
                            lv = 1'b1;
                            ls = w_now_reg;
                        end
                        else if (reached(w_now_reg, ls, w_cls_reg.hold))
                        begin
                            md      = MODE_SLEEPING;
                            ms      = w_now_reg;
                            changed = 1'b1;
                            entered = 1'b1;
                            cv      = 1'b0;
                        end
                    end
                    else
                    begin
                        lv = 1'b0;
                    end
                end
                MODE_SLEEPING:
                begin
                    if (!w_cls_reg.sleep)
                    begin
                        cv      = 1'b1;
                        cs      = w_now_reg;
                        md      = MODE_RECOVERING;
                        ms      = w_now_reg;
                        changed = 1'b1;
                    end
                end
                MODE_RECOVERING:
                begin
                    if (w_cls_reg.sleep)
                    begin
                        cv      = 1'b0;
                        md      = MODE_SLEEPING;
                        ms      = w_now_reg;
                        changed = 1'b1;
                    end
                    else if (cv && reached(w_now_reg, cs, cfg.recovery_hold))
                    begin
                        md      = MODE_NORMAL;
                        ms      = w_now_reg;
                        changed = 1'b1;
                        lv      = 1'b0;
                        cv      = 1'b0;
                    end
                end
                default:
                begin
                    md = MODE_NORMAL;
                end
            endcase
        end

        tis       = (w_now_reg >= ms) ? (w_now_reg - ms) : '0;
        new_entry = {1'b1, md, lv, cv, av, ms, ls, cs, as_t};
    end

    // Table write port: zeros during the clear pass, the new entry on commit
    always_comb
    begin
        wr_en   = clearing || commit;
        wr_addr = clearing ? clr_cnt_reg : w_idx_reg;
        wr_data = clearing ? '0 : new_entry;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= table_mem[q_idx];
        end
    end

    // Result register: load on commit, drop once transferred
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            track_state_reg   <= md;
            state_changed_reg <= changed;
            sleep_entered_reg <= entered;
            time_in_state_reg <= STAMP_W'(tis);
        end
    end

    assign out_valid        = out_valid_reg;
    assign track_state      = track_state_reg;
    assign state_changed    = state_changed_reg;
    assign sleep_entered    = sleep_entered_reg;
    assign time_in_state_ms = time_in_state_reg;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the per-track sleep state machine
// Drives track observations through the valid/ready input, models every
// track's mode and timers alongside the design, and checks each result field
// by field in arrival order. Registers are rewritten between phases while the
// block is idle, and both sides idle at random in varying proportions.
// ----------------------------------------------------------------------------
module tb_top;
    import ptssm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TRACKS  = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_LINES   = 40;
    localparam int PHASE_ITEMS = 230;

    // Evidence codes beyond the absent code
    localparam logic [1:0] SIG_FALSE     = 2'd1;
    localparam logic [1:0] SIG_TRUE      = 2'd2;
    localparam logic [1:0] SIG_TRUE_ALT  = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [STAMP_W-1:0]    stamp;
        logic [1:0]            sleep_sig;
        logic [1:0]            suspect_sig;
        logic [CFG_DATA_W-1:0] hold_ovr;
    } observation_t;

    typedef struct packed {
        mode_t              state;
        logic               changed;
        logic               entered;
        logic [STAMP_W-1:0] dwell;
    } track_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [ID_W-1:0]       track_id = '0;
    logic [STAMP_W-1:0]    timestamp_ms = '0;
    logic [1:0]            sleep_signal = '0;
    logic [1:0]            suspect_signal = '0;
    logic [CFG_DATA_W-1:0] hold_override_ms = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            track_state;
    logic                  state_changed;
    logic                  sleep_entered;
    logic [STAMP_W-1:0]    time_in_state_ms;

    observation_t  observations[$];
    track_report_t due_reports[$];
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            error_count = 0;
    int            stall_cycles = 0;

    // Model copy of the registers
    logic [CFG_DATA_W-1:0] hold_reg = SLEEP_HOLD_RST;
    logic [CFG_DATA_W-1:0] recovery_reg = RECOVERY_HOLD_RST;
    logic [CFG_DATA_W-1:0] absent_reg = ABSENT_RESET_RST;

    // Model copy of the per-track table
    logic               trk_seen [NUM_TRACKS];
    mode_t              trk_mode [NUM_TRACKS];
    logic [STAMP_W-1:0] trk_since [NUM_TRACKS];
    logic               low_valid [NUM_TRACKS];
    logic [STAMP_W-1:0] low_from [NUM_TRACKS];
    logic               calm_valid [NUM_TRACKS];
    logic [STAMP_W-1:0] calm_from [NUM_TRACKS];
    logic               absent_valid [NUM_TRACKS];
    logic [STAMP_W-1:0] absent_from [NUM_TRACKS];

    // Stimulus history per track
    logic [STAMP_W-1:0] gen_clock [NUM_TRACKS];
    logic [1:0]         gen_sleep [NUM_TRACKS];
    int                 focus_base = 0;

    per_track_sleep_state_machine u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .track_id         (track_id),
        .timestamp_ms     (timestamp_ms),
        .sleep_signal     (sleep_signal),
        .suspect_signal   (suspect_signal),
        .hold_override_ms (hold_override_ms),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .track_state      (track_state),
        .state_changed    (state_changed),
        .sleep_entered    (sleep_entered),
        .time_in_state_ms (time_in_state_ms)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Elapsed time, clamped at zero when time runs backwards
    function automatic logic [STAMP_W-1:0] span(logic [STAMP_W-1:0] now,
                                                logic [STAMP_W-1:0] from);
        return (now >= from) ? now - from : '0;
    endfunction

    function automatic logic switch_mode(int k, mode_t m, logic [STAMP_W-1:0] now);
        if (trk_mode[k] == m)
            return 1'b0;
        trk_mode[k] = m;
        trk_since[k] = now;
        return 1'b1;
    endfunction

    function automatic logic drop_to_normal(int k, logic [STAMP_W-1:0] now);
        logic ch;
        ch = switch_mode(k, MODE_NORMAL, now);
        low_valid[k] = 1'b0;
        calm_valid[k] = 1'b0;
        absent_valid[k] = 1'b0;
        return ch;
    endfunction

    // Advance one track by one observation and return its report
    function automatic track_report_t advance_track(observation_t ob);
        int                    k;
        logic [STAMP_W-1:0]    now;
        logic [CFG_DATA_W-1:0] hold;
        logic                  sleepy;
        logic                  cand;
        track_report_t         r;
        k = int'(ob.id) % NUM_TRACKS;
        now = ob.stamp;
        hold = (ob.hold_ovr != '0) ? ob.hold_ovr : hold_reg;
        r = '0;
        if (!trk_seen[k])
        begin
            trk_seen[k] = 1'b1;
            trk_mode[k] = MODE_NORMAL;
            trk_since[k] = now;
            low_valid[k] = 1'b0;
            calm_valid[k] = 1'b0;
            absent_valid[k] = 1'b0;
        end
        if (ob.sleep_sig == SIG_ABSENT)
        begin
            if (!absent_valid[k])
            begin
                absent_valid[k] = 1'b1;
                absent_from[k] = now;
            end
            else if (span(now, absent_from[k]) >= absent_reg)
                r.changed = drop_to_normal(k, now);
        end
        else
        begin
            sleepy = (ob.sleep_sig >= SIG_TRUE);
            cand = (ob.suspect_sig == SIG_ABSENT) ? sleepy : (ob.suspect_sig >= SIG_TRUE);
            absent_valid[k] = 1'b0;
            case (trk_mode[k])
                MODE_NORMAL:
                begin
                    if (cand)
                    begin
                        low_valid[k] = sleepy;
                        low_from[k] = now;
                        r.changed = switch_mode(k, MODE_SUSPECTED, now);
                    end
                end
                MODE_SUSPECTED:
                begin
                    if (!cand)
                        r.changed = drop_to_normal(k, now);
                    else if (sleepy)
                    begin
                        if (!low_valid[k])
                        begin
                            low_valid[k] = 1'b1;
                            low_from[k] = now;
                        end
                        else if (span(now, low_from[k]) >= hold)
                        begin
                            r.changed = switch_mode(k, MODE_SLEEPING, now);
                            r.entered = r.changed;
                            calm_valid[k] = 1'b0;
                        end
                    end
                    else
                        low_valid[k] = 1'b0;
                end
                MODE_SLEEPING:
                begin
                    if (!sleepy)
                    begin
                        calm_valid[k] = 1'b1;
                        calm_from[k] = now;
                        r.changed = switch_mode(k, MODE_RECOVERING, now);
                    end
                end
                default:
                begin
                    if (sleepy)
                    begin
                        calm_valid[k] = 1'b0;
                        r.changed = switch_mode(k, MODE_SLEEPING, now);
                    end
                    else if (calm_valid[k] && span(now, calm_from[k]) >= recovery_reg)
                        r.changed = drop_to_normal(k, now);
                end
            endcase
        end
        r.state = trk_mode[k];
        r.dwell = span(now, trk_since[k]);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (error_count < MAX_LINES)
            $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SLEEP_HOLD:    hold_reg = value;
            CFG_RECOVERY_HOLD: recovery_reg = value;
            CFG_ABSENT_RESET:  absent_reg = value;
            default:           ;
        endcase
    endtask

    task automatic push_obs(int id, logic [STAMP_W-1:0] stamp, logic [1:0] ss,
                            logic [1:0] su, logic [CFG_DATA_W-1:0] ovr);
        observation_t ob;
        ob.id = id[ID_W-1:0];
        ob.stamp = stamp;
        ob.sleep_sig = ss;
        ob.suspect_sig = su;
        ob.hold_ovr = ovr;
        observations = {observations, ob};
    endtask

    function automatic logic [1:0] pick_signal(int absent_w, int false_w, int true_w);
        int r;
        r = $urandom_range(0, 19);
        if (r < absent_w)
            return SIG_ABSENT;
        if (r < absent_w + false_w)
            return SIG_FALSE;
        if (r < absent_w + false_w + true_w)
            return SIG_TRUE;
        return SIG_TRUE_ALT;
    endfunction

    // Build one random observation: sticky evidence, steps placed near timer limits
    function automatic observation_t random_observation();
        observation_t      ob;
        int                k;
        longint unsigned   thr;
        longint unsigned   step;
        k = ($urandom_range(0, 99) < 85) ? focus_base + $urandom_range(0, 7)
                                         : $urandom_range(0, NUM_TRACKS - 1);
        ob.id = k[ID_W-1:0];
        if ($urandom_range(0, 99) < 70)
            ob.sleep_sig = gen_sleep[k];
        else
            ob.sleep_sig = pick_signal(4, 5, 9);
        gen_sleep[k] = ob.sleep_sig;
        ob.suspect_sig = pick_signal(12, 3, 3);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: ob.hold_ovr = '0;
            6:                ob.hold_ovr = 32'd1;
            7:                ob.hold_ovr = '1;
            8:                ob.hold_ovr = $urandom;
            default:          ob.hold_ovr = $urandom_range(1, 200);
        endcase
        case ($urandom_range(0, 2))
            0:       thr = (ob.hold_ovr != '0) ? ob.hold_ovr : hold_reg;
            1:       thr = recovery_reg;
            default: thr = absent_reg;
        endcase
        if (ob.sleep_sig == SIG_ABSENT && $urandom_range(0, 1) == 0)
            thr = absent_reg;
        case ($urandom_range(0, 9))
            0:          step = 0;
            1, 2, 3, 4: step = $urandom_range(0, 32'(thr / 2));
            5:          step = (thr > 0) ? thr - 1 : 0;
            6:          step = thr;
            7:          step = thr + $urandom_range(0, 3);
            default:    step = $urandom_range(0, 100);
        endcase
        // Step backwards now and then
        if ($urandom_range(0, 39) == 0)
            gen_clock[k] = gen_clock[k] - $urandom_range(1, 500);
        else
            gen_clock[k] = gen_clock[k] + step[STAMP_W-1:0];
        ob.stamp = gen_clock[k];
        return ob;
    endfunction

    task automatic wait_drained();
        while (observations.size() != 0 || in_valid || due_reports.size() != 0)
            @(posedge clk);
    endtask

    // Input driver: predict on each transfer, then offer the next observation
    always @(posedge clk or negedge rst_n)
    begin
        observation_t ob;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                ob.id = track_id;
                ob.stamp = timestamp_ms;
                ob.sleep_sig = sleep_signal;
                ob.suspect_sig = suspect_signal;
                ob.hold_ovr = hold_override_ms;
                due_reports = {due_reports, advance_track(ob)};
            end
            if (!in_valid || in_ready)
            begin
                if (observations.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    ob = observations[0];
                    observations.delete(0);
                    track_id <= ob.id;
                    timestamp_ms <= ob.stamp;
                    sleep_signal <= ob.sleep_sig;
                    suspect_signal <= ob.suspect_sig;
                    hold_override_ms <= ob.hold_ovr;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: check each transfer against the oldest report
    always @(posedge clk or negedge rst_n)
    begin
        track_report_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (due_reports.size() == 0)
                    report_mismatch("unexpected result", {62'd0, track_state}, 64'd0);
                else
                begin
                    want = due_reports[0];
                    due_reports.delete(0);
                    if (track_state !== want.state)
                        report_mismatch("track_state", track_state, want.state);
                    if (state_changed !== want.changed)
                        report_mismatch("state_changed", state_changed, want.changed);
                    if (sleep_entered !== want.entered)
                        report_mismatch("sleep_entered", sleep_entered, want.entered);
                    if (time_in_state_ms !== want.dwell)
                        report_mismatch("time_in_state_ms", time_in_state_ms, want.dwell);
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: count cycles with work outstanding but no transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (observations.size() == 0 && !in_valid && due_reports.size() == 0))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [STAMP_W-1:0]    top;
        logic [CFG_DATA_W-1:0] settings [6][3];
        for (int i = 0; i < NUM_TRACKS; i++)
        begin
            trk_seen[i] = 1'b0;
            gen_clock[i] = STAMP_W'({$urandom, $urandom});
            gen_sleep[i] = SIG_TRUE;
        end
        settings[0] = '{32'd1000, 32'd500, 32'd300};
        settings[1] = '{32'd50, 32'd30, 32'd20};
        settings[2] = '{32'd1, 32'd1, 32'd1};
        settings[3] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        settings[4] = '{32'd0, 32'd0, 32'd0};
        settings[5] = '{$urandom_range(1, 5000), $urandom_range(1, 5000),
                        $urandom_range(1, 5000)};
        top = '1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 14;
        recv_idle_pct = 79;

        // Directed: full cycle through every mode with reset register values
        push_obs(0, 40'd0, SIG_TRUE, SIG_ABSENT, '0);
        push_obs(0, 40'd5000, SIG_TRUE, SIG_ABSENT, '0);
        push_obs(0, 40'd10000, SIG_TRUE, SIG_ABSENT, '0);
        push_obs(0, 40'd10500, SIG_TRUE_ALT, SIG_ABSENT, '0);
        push_obs(0, 40'd11000, SIG_FALSE, SIG_ABSENT, '0);
        push_obs(0, 40'd12000, SIG_TRUE_ALT, SIG_ABSENT, '0);
        push_obs(0, 40'd12100, SIG_FALSE, SIG_ABSENT, '0);
        push_obs(0, 40'd15100, SIG_FALSE, SIG_ABSENT, '0);
        push_obs(0, 40'd15200, SIG_ABSENT, SIG_TRUE, '0);
        push_obs(0, 40'd17200, SIG_ABSENT, SIG_ABSENT, '0);
        // Suspect evidence overriding sleep evidence, top timestamp, time running back
        push_obs(1, top, SIG_FALSE, SIG_TRUE, '0);
        push_obs(1, top, SIG_TRUE, SIG_TRUE_ALT, 32'd1);
        push_obs(1, 40'd100, SIG_TRUE, SIG_ABSENT, 32'd1);
        push_obs(1, top, SIG_TRUE, SIG_ABSENT, 32'hFFFF_FFFF);
        push_obs(1, top, SIG_FALSE, SIG_TRUE, '0);
        push_obs(1, top, SIG_FALSE, SIG_FALSE, '0);
        // Absent evidence on a fresh track and a timeout while suspected
        push_obs(63, 40'h55_AAAA_5555, SIG_ABSENT, SIG_TRUE_ALT, 32'hAAAA_5555);
        push_obs(63, 40'h55_AAAA_5D25, SIG_ABSENT, SIG_FALSE, 32'h5555_AAAA);
        push_obs(2, 40'd0, SIG_TRUE, SIG_TRUE, '0);
        push_obs(2, 40'd100, SIG_ABSENT, SIG_ABSENT, '0);
        push_obs(2, 40'd2100, SIG_ABSENT, SIG_ABSENT, '0);
        // Per-item hold, then recovery after absent evidence while sleeping
        push_obs(3, 40'd1000, SIG_TRUE, SIG_ABSENT, '0);
        push_obs(3, 40'd1007, SIG_TRUE, SIG_ABSENT, 32'd7);
        push_obs(3, 40'd1008, SIG_ABSENT, SIG_ABSENT, '0);
        push_obs(3, 40'd1009, SIG_FALSE, SIG_ABSENT, '0);
        wait_drained();

        // Random phases, one register setting each, idling pattern every two
        for (int p = 0; p < 6; p++)
        begin
            case (p / 2)
                0:
                begin
                    send_idle_pct = 14;
                    recv_idle_pct = 79;
                end
                1:
                begin
                    send_idle_pct = 79;
                    recv_idle_pct = 14;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_reg(CFG_SLEEP_HOLD, settings[p][0]);
            write_reg(CFG_RECOVERY_HOLD, settings[p][1]);
            write_reg(CFG_ABSENT_RESET, settings[p][2]);
            focus_base = $urandom_range(0, NUM_TRACKS - 8);
            for (int n = 0; n < PHASE_ITEMS; n++)
                observations = {observations, random_observation()};
            wait_drained();
        end

        // Let any stray result surface before closing
        repeat (10) @(posedge clk);
        if (due_reports.size() != 0)
            report_mismatch("results never arrived", 64'(due_reports.size()), 64'd0);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ptssm_pkg.sv
rtl/ptssm_front.sv
rtl/ptssm_queue.sv
rtl/ptssm_back.sv
rtl/per_track_sleep_state_machine.sv
tb/tb_top.sv
